// File: hw/rtl/srld_pkg.sv
// Shared types and codes for the sprite run-length decoder.
// No dependencies; srld_step and the top level import this package.
package srld_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LITTLE_ENDIAN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_COLOR     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;

    // Input operations.
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_NEW    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_PIXEL   = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // Parse phases.
    localparam logic [1:0] PH_START   = 2'd0;
    localparam logic [1:0] PH_SECOND  = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;

    typedef struct packed {
        logic        mode;
        logic        little_endian;
        logic [15:0] key_color;
        logic [31:0] image_size;
    } cfg_t;

    typedef struct packed {
        logic [31:0] pixel_position;
        logic [7:0]  low_byte_held;
        logic        byte_phase;
        logic [1:0]  parse_phase;
        logic [15:0] run_remaining;
        logic [15:0] run_color;
        logic [7:0]  current_alpha;
        logic [7:0]  literal_remaining;
        logic        error_latched;
    } state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pixel_color;
        logic [7:0]  pixel_alpha;
        logic        last_pixel;
    } result_t;

endpackage

// File: hw/rtl/srld_stream_if.sv
// Input channel of the sprite decoder: stream bytes, drain ticks and restarts.
// Depends on nothing but the handshake convention valid/ready.
interface srld_stream_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

// File: hw/rtl/srld_pixel_if.sv
// Output channel of the sprite decoder: one pixel or status word per handshake.
// Depends on nothing but the handshake convention valid/ready.
interface srld_pixel_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] pixel_color;
    logic [7:0]  pixel_alpha;
    logic        last_pixel;

    modport source (output valid, output status, output pixel_color, output pixel_alpha,
                    output last_pixel, input ready);
    modport sink (input valid, input status, input pixel_color, input pixel_alpha,
                  input last_pixel, output ready);
endinterface

// File: hw/rtl/srld_step.sv
// Next-state and result logic for one accepted word of the sprite decoder.
// Depends on srld_pkg for the state, configuration and result types.
module srld_step (
    input  srld_pkg::cfg_t    cfg,
    input  srld_pkg::state_t  state,
    input  logic [1:0]        op,
    input  logic [7:0]        data_byte,
    output srld_pkg::state_t  state_next,
    output logic              result_valid,
    output srld_pkg::result_t result
);
    import srld_pkg::*;

    logic [32:0] left_diff;
    logic [31:0] pixels_left;
    logic        left_zero;
    logic [31:0] position_inc;
    logic        inc_is_last;
    logic [15:0] word;
    logic [7:0]  literal_dec;

    assign left_diff    = {1'b0, cfg.image_size} - {1'b0, state.pixel_position};
    assign pixels_left  = left_diff[32] ? 32'd0 : left_diff[31:0];
    assign left_zero    = (pixels_left == 32'd0);
    assign position_inc = state.pixel_position + 32'd1;
    assign inc_is_last  = (position_inc == cfg.image_size);
    assign word         = cfg.little_endian ? {data_byte, state.low_byte_held}
                                            : {state.low_byte_held, data_byte};
    assign literal_dec  = (state.literal_remaining != 8'd0) ?
                          (state.literal_remaining - 8'd1) : 8'd0;

    always_comb
    begin
        state_next   = state;
        result_valid = 1'b0;
        result       = '0;

        case (op)
            OP_NEW:
            begin
                state_next = '0;
            end
            OP_BYTE, OP_TICK:
            begin
                if (state.error_latched)
                begin
                    result_valid  = 1'b1;
                    result.status = ST_ERROR;
                end
                else if (op == OP_TICK)
                begin
                    if (state.run_remaining != 16'd0)
                    begin
                        result_valid = 1'b1;
                        if (left_zero)
                        begin
                            state_next.run_remaining = 16'd0;
                            state_next.error_latched = 1'b1;
                            result.status            = ST_ERROR;
                        end
                        else
                        begin
                            state_next.run_remaining  = state.run_remaining - 16'd1;
                            state_next.pixel_position = position_inc;
                            result.status             = ST_PIXEL;
                            result.pixel_color        = state.run_color;
                            result.pixel_alpha        = state.current_alpha;
                            result.last_pixel         = inc_is_last;
                        end
                    end
                end
                else if (state.run_remaining != 16'd0)
                begin
                    result_valid  = 1'b1;
                    result.status = ST_REFUSED;
                end
                else if (!cfg.mode)
                begin
                    // Packed mode: pixel words, and a count word after a key pixel.
                    if (state.parse_phase != PH_SECOND)
                    begin
                        state_next.parse_phase = PH_START;
                        if (left_zero)
                        begin
                            result_valid             = 1'b1;
                            result.status            = ST_ERROR;
                            state_next.error_latched = 1'b1;
                        end
                        else if (!state.byte_phase)
                        begin
                            state_next.low_byte_held = data_byte;
                            state_next.byte_phase    = 1'b1;
                        end
                        else
                        begin
                            state_next.byte_phase = 1'b0;
                            if (word == cfg.key_color)
                            begin
                                state_next.parse_phase = PH_SECOND;
                            end
                            state_next.pixel_position = position_inc;
                            result_valid              = 1'b1;
                            result.status             = ST_PIXEL;
                            result.pixel_color        = word;
                            result.last_pixel         = inc_is_last;
                        end
                    end
                    else if (!state.byte_phase)
                    begin
                        state_next.low_byte_held = data_byte;
                        state_next.byte_phase    = 1'b1;
                    end
                    else
                    begin
                        state_next.byte_phase = 1'b0;
                        if ({16'd0, word} > pixels_left)
                        begin
                            result_valid             = 1'b1;
                            result.status            = ST_ERROR;
                            state_next.error_latched = 1'b1;
                        end
                        else
                        begin
                            state_next.run_remaining = word;
                            state_next.run_color     = cfg.key_color;
                            state_next.current_alpha = 8'd0;
                            state_next.parse_phase   = PH_START;
                        end
                    end
                end
                else if (state.parse_phase == PH_LITERAL)
                begin
                    // Alpha mode, literal color words.
                    if (!state.byte_phase)
                    begin
                        state_next.low_byte_held = data_byte;
                        state_next.byte_phase    = 1'b1;
                    end
                    else
                    begin
                        state_next.byte_phase        = 1'b0;
                        state_next.literal_remaining = literal_dec;
                        if (literal_dec == 8'd0)
                        begin
                            state_next.parse_phase = PH_START;
                        end
                        state_next.pixel_position = position_inc;
                        result_valid              = 1'b1;
                        result.status             = ST_PIXEL;
                        result.pixel_color        = word;
                        result.pixel_alpha        = state.current_alpha;
                        result.last_pixel         = inc_is_last;
                    end
                end
                else if (state.parse_phase == PH_SECOND)
                begin
                    // Alpha byte: zero queues a black run, otherwise literals follow.
                    state_next.byte_phase    = 1'b0;
                    state_next.current_alpha = data_byte;
                    if (data_byte == 8'd0)
                    begin
                        state_next.run_remaining     = {8'd0, state.literal_remaining};
                        state_next.run_color         = 16'd0;
                        state_next.literal_remaining = 8'd0;
                        state_next.parse_phase       = PH_START;
                    end
                    else
                    begin
                        state_next.parse_phase = PH_LITERAL;
                    end
                end
                else
                begin
                    // Run length byte.
                    state_next.byte_phase  = 1'b0;
                    state_next.parse_phase = PH_START;
                    if (left_zero || (data_byte == 8'd0) ||
                        ({24'd0, data_byte} > pixels_left))
                    begin
                        result_valid             = 1'b1;
                        result.status            = ST_ERROR;
                        state_next.error_latched = 1'b1;
                    end
                    else
                    begin
                        state_next.literal_remaining = data_byte;
                        state_next.parse_phase       = PH_SECOND;
                    end
                end
            end
            default:
            begin
                // The unused operation changes nothing and gives no word.
                state_next = state;
            end
        endcase
    end

endmodule

// File: hw/rtl/sprite_run_length_decoder_unit.sv
// Top level of the sprite run-length decoder with 16-bit pixels.
// Depends on srld_pkg, srld_stream_if, srld_pixel_if and srld_step.
//
//   Channel   Direction  Handshake          Content
//   stream    in         valid/ready        op, data_byte
//   pixels    out        valid/ready        status, pixel_color, pixel_alpha, last_pixel
//   cfg       in         cfg_we, no stall   cfg_index, cfg_data
//
// The block takes one word per cycle while ready. Each accepted word is decoded in the
// cycle it arrives, and its result, if any, is held in a single output register.
// The stream is ready whenever that register is empty or is being emptied in the
// same cycle, so a stalled pixel channel stops the stream only while a result waits.
// Reset (rst_n low, asynchronous) clears the decode state and the output valid flag and
// loads the configuration defaults; the image size product is kept in a register
// that is refreshed on every width or height write.
module sprite_run_length_decoder_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [srld_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [srld_pkg::CFG_DATA_W-1:0]   cfg_data,
    srld_stream_if.sink                       stream,
    srld_pixel_if.source                      pixels
);
    import srld_pkg::*;

    logic        mode_reg;
    logic        little_endian_reg;
    logic [15:0] key_color_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [31:0] image_size_reg;

    state_t      state_reg;
    state_t      state_next;
    logic        out_valid_reg;
    result_t     out_data_reg;

    cfg_t        cfg;
    logic        step_valid;
    result_t     step_result;
    logic        accept;

    // Configuration registers. The size product is formed as the write happens,
    // so the next accepted word already sees the new size.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= 1'b0;
            little_endian_reg <= 1'b0;
            key_color_reg     <= 16'd0;
            image_width_reg   <= 16'd1;
            image_height_reg  <= 16'd1;
            image_size_reg    <= 32'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:          mode_reg          <= cfg_data[0];
                CFG_LITTLE_ENDIAN: little_endian_reg <= cfg_data[0];
                CFG_KEY_COLOR:     key_color_reg     <= cfg_data;
                CFG_IMAGE_WIDTH:
                begin
                    image_width_reg <= cfg_data;
                    image_size_reg  <= {16'd0, cfg_data} * {16'd0, image_height_reg};
                end
                CFG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= cfg_data;
                    image_size_reg   <= {16'd0, image_width_reg} * {16'd0, cfg_data};
                end
                default:
                begin
                    // Indexes past the register list are ignored.
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    assign cfg.mode          = mode_reg;
    assign cfg.little_endian = little_endian_reg;
    assign cfg.key_color     = key_color_reg;
    assign cfg.image_size    = image_size_reg;

    srld_step u_step (
        .cfg          (cfg),
        .state        (state_reg),
        .op           (stream.op),
        .data_byte    (stream.data_byte),
        .state_next   (state_next),
        .result_valid (step_valid),
        .result       (step_result)
    );

    assign stream.ready = !out_valid_reg || pixels.ready;
    assign accept       = stream.valid && stream.ready;

    // Decode state advances on every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output register: loaded by an accepted word that yields a result,
    // emptied when the pixel channel takes it and nothing replaces it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= step_valid;
        end
        else if (pixels.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && step_valid)
        begin
            out_data_reg <= step_result;
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.status      = out_data_reg.status;
    assign pixels.pixel_color = out_data_reg.pixel_color;
    assign pixels.pixel_alpha = out_data_reg.pixel_alpha;
    assign pixels.last_pixel  = out_data_reg.last_pixel;

endmodule
